// ===== hw/rtl/rpg_pkg.sv =====
// rpg_pkg: shared types and constants of the rgb prewitt gradient magnitude core
// depends on nothing; used by rpg_lane, rgb_prewitt_gradient_magnitude_core and the testbench
`timescale 1ns / 1ps
`default_nettype none

package rpg_pkg;

   localparam int CHAN_W        = 8;
   localparam int NUM_IN_CHAN   = 3;
   localparam int PIX_W         = CHAN_W * NUM_IN_CHAN;
   localparam int OUT_COL_W     = 11;
   localparam int ROW_W         = 12;
   localparam int CFG_W         = 12;
   localparam int APB_ADDR_W    = 3;
   localparam int APB_DATA_W    = 32;
   localparam int ROOT_STEPS    = 8;
   localparam int ROOT_CNT_W    = $clog2(ROOT_STEPS);

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int CHANNELS_DEF  = 3;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [CFG_W-1:0] MIN_DIM          = 12'd3;

   // register select taken from paddr[2]
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic              frame_start;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] out_column;
      logic [ROW_W-1:0]     out_row;
      logic [CHAN_W-1:0]    red_edge;
      logic [CHAN_W-1:0]    green_edge;
      logic [CHAN_W-1:0]    blue_edge;
      logic                 frame_done;
   } rsp_type;

   typedef struct packed {
      logic calc;   // form gradients and squares
      logic sum;    // add squares, seed the root
      logic root;   // one root iteration
   } lane_ctrl_type;

   typedef struct packed {
      logic [CHAN_W-1:0] left_top;
      logic [CHAN_W-1:0] left_mid;
      logic [CHAN_W-1:0] left_bot;
      logic [CHAN_W-1:0] cen_top;
      logic [CHAN_W-1:0] cen_bot;
      logic [CHAN_W-1:0] right_top;
      logic [CHAN_W-1:0] right_mid;
      logic [CHAN_W-1:0] right_bot;
   } lane_win_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rpg_ram.sv =====
// rpg_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module rpg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rpg_lane.sv =====
// rpg_lane: prewitt gradients, squared magnitude and bit-serial square root of one channel
// depends on rpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpg_lane (
   input  wire logic                       clock,
   input  wire rpg_pkg::lane_ctrl_type     ctrl,
   input  wire rpg_pkg::lane_win_type      win,
   output logic [rpg_pkg::CHAN_W-1:0]      mag
);

   localparam logic [15:0] ROOT_BIT_INIT = 16'h4000;

   logic [9:0]  right_sum, left_sum, up_sum, down_sum;
   logic [10:0] dx_diff, dy_diff;
   logic [9:0]  dx_abs, dy_abs;
   logic [19:0] sqx_ff, sqy_ff;
   logic [20:0] sq_sum;
   logic        sat_ff;
   logic [15:0] rem_ff, res_ff, bit_ff;
   logic [16:0] trial;

   assign right_sum = 10'(win.right_top) + 10'(win.right_mid) + 10'(win.right_bot);
   assign left_sum  = 10'(win.left_top) + 10'(win.left_mid) + 10'(win.left_bot);
   assign up_sum    = 10'(win.left_top) + 10'(win.cen_top) + 10'(win.right_top);
   assign down_sum  = 10'(win.left_bot) + 10'(win.cen_bot) + 10'(win.right_bot);

   assign dx_diff = {1'b0, right_sum} - {1'b0, left_sum};
   assign dy_diff = {1'b0, up_sum} - {1'b0, down_sum};
   assign dx_abs  = dx_diff[10] ? 10'(-dx_diff) : dx_diff[9:0];
   assign dy_abs  = dy_diff[10] ? 10'(-dy_diff) : dy_diff[9:0];

   assign sq_sum = 21'(sqx_ff) + 21'(sqy_ff);
   assign trial  = 17'(res_ff) + 17'(bit_ff);

   always_ff @(posedge clock) begin
      if (ctrl.calc) begin
         sqx_ff <= 20'(dx_abs) * 20'(dx_abs);
         sqy_ff <= 20'(dy_abs) * 20'(dy_abs);
      end
      if (ctrl.sum) begin
         // root of 2^16 or more saturates anyway
         sat_ff <= |sq_sum[20:16];
         rem_ff <= sq_sum[15:0];
         res_ff <= '0;
         bit_ff <= ROOT_BIT_INIT;
      end else if (ctrl.root) begin
         if (17'(rem_ff) >= trial) begin
            rem_ff <= 16'(17'(rem_ff) - trial);
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign mag = sat_ff ? {rpg_pkg::CHAN_W{1'b1}} : res_ff[rpg_pkg::CHAN_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_prewitt_gradient_magnitude_core.sv =====
// rgb_prewitt_gradient_magnitude_core: streaming 3x3 prewitt edge magnitude on rgb pixels
// depends on rpg_pkg, rpg_ram (two line buffers) and rpg_lane (one per color channel)
//
//   channel   ports                         direction   transaction
//   request   req_valid/req_stall/req_data  in          one rgb pixel, raster order
//   response  rsp_valid/rsp_stall/rsp_data  out         edge magnitudes of one interior pixel
//   csr       psel/penable/pwrite/paddr/... in          frame_width at 0, frame_height at 4
//
// a pixel that yields no result passes through accept, line buffer read and window update
// a pixel that yields a result passes through accept, window, add of squares,
// the bit-serial square root (one result bit per cycle) and the hand-off to the
// output register; the hand-off waits while the output register still holds a result
// reset is synchronous and active high; the line buffers are not cleared
// the output register lets the next pixel be accepted while a result waits on rsp_stall
`timescale 1ns / 1ps
`default_nettype none

module rgb_prewitt_gradient_magnitude_core #(
   parameter int MAX_WIDTH = rpg_pkg::MAX_WIDTH_DEF,
   parameter int CHANNELS  = rpg_pkg::CHANNELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire rpg_pkg::req_type                  req_data,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rpg_pkg::rsp_type                       rsp_data,
   // csr port
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rpg_pkg::APB_ADDR_W-1:0]    paddr,
   input  wire logic [rpg_pkg::APB_DATA_W-1:0]    pwdata,
   output logic      [rpg_pkg::APB_DATA_W-1:0]    prdata,
   output logic                                   pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   // wide enough for the column, the output column and the clamped width plus one
   localparam int XW    = ((COL_W > rpg_pkg::CFG_W) ? COL_W : rpg_pkg::CFG_W) + 2;
   localparam int RW    = rpg_pkg::ROW_W + 1;
   localparam int PW    = rpg_pkg::PIX_W;
   localparam int CW    = rpg_pkg::CHAN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_SUM,
      ST_ROOT,
      ST_HOLD
   } state_type;

   // control state
   state_type                       state_ff, state_in;
   logic [COL_W-1:0]                col_ff, col_in;
   logic [rpg_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [rpg_pkg::ROOT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            out_valid_ff, out_valid_in;
   logic [rpg_pkg::CFG_W-1:0]       frame_width_ff, frame_height_ff;
   logic [PW-1:0]                   win_ff [6];

   // payload of the item in flight
   logic [COL_W-1:0]                item_col_ff;
   logic [rpg_pkg::ROW_W-1:0]       item_row_ff;
   logic [PW-1:0]                   pix_ff;
   logic [rpg_pkg::OUT_COL_W-1:0]   res_col_ff;
   logic [rpg_pkg::ROW_W-1:0]       res_row_ff;
   logic                            res_done_ff;
   rpg_pkg::rsp_type                out_ff;

   logic                            req_accept, cfg_write;
   logic [COL_W-1:0]                start_col;
   logic [rpg_pkg::ROW_W-1:0]       start_row;
   logic [PW-1:0]                   top_rd, mid_rd;
   logic [XW-1:0]                   wid_raw, wid_eff, col_x, col_next, col_m1;
   logic [RW-1:0]                   hgt_eff, row_x, row_next;
   logic                            emit, col_wrap, row_wrap, last_pix, out_load;
   rpg_pkg::lane_ctrl_type          lane_ctrl;
   logic [2:0][CW-1:0]              lane_mag;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      case (paddr[2])
         rpg_pkg::REG_FRAME_WIDTH:  prdata = rpg_pkg::APB_DATA_W'(frame_width_ff);
         rpg_pkg::REG_FRAME_HEIGHT: prdata = rpg_pkg::APB_DATA_W'(frame_height_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- geometry
   // width clamped to 3..MAX_WIDTH, height to at least 3
   assign wid_raw = XW'(frame_width_ff);
   always_comb begin
      if (wid_raw < XW'(rpg_pkg::MIN_DIM)) begin
         wid_eff = XW'(rpg_pkg::MIN_DIM);
      end else if (wid_raw > XW'(MAX_WIDTH)) begin
         wid_eff = XW'(MAX_WIDTH);
      end else begin
         wid_eff = wid_raw;
      end
   end
   assign hgt_eff = (frame_height_ff < rpg_pkg::MIN_DIM) ? RW'(rpg_pkg::MIN_DIM)
                                                         : RW'(frame_height_ff);

   assign col_x    = XW'(item_col_ff);
   assign col_next = col_x + XW'(1);
   assign col_m1   = col_x - XW'(1);
   assign row_x    = RW'(item_row_ff);
   assign row_next = row_x + RW'(1);
   assign col_wrap = col_next >= wid_eff;
   assign row_wrap = row_next >= hgt_eff;
   assign emit     = (item_col_ff >= COL_W'(2)) && (item_row_ff >= rpg_pkg::ROW_W'(2));
   assign last_pix = (col_next == wid_eff) && (row_next == hgt_eff);

   // frame_start puts the pixel at the origin
   assign start_col = req_data.frame_start ? '0 : col_ff;
   assign start_row = req_data.frame_start ? '0 : row_ff;

   // ---------------------------------------------------------------- line buffers
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   rpg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_line (
      .clock   (clock),
      .wr_en   (state_ff == ST_CALC),
      .wr_addr (item_col_ff),
      .wr_data (mid_rd),
      .rd_en   (req_accept),
      .rd_addr (start_col),
      .rd_data (top_rd)
   );

   rpg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_line (
      .clock   (clock),
      .wr_en   (state_ff == ST_CALC),
      .wr_addr (item_col_ff),
      .wr_data (pix_ff),
      .rd_en   (req_accept),
      .rd_addr (start_col),
      .rd_data (mid_rd)
   );

   // ---------------------------------------------------------------- lanes
   // window slots: 0..2 left column top/mid/bottom, 3..5 centre column
   assign lane_ctrl.calc = (state_ff == ST_CALC);
   assign lane_ctrl.sum  = (state_ff == ST_SUM);
   assign lane_ctrl.root = (state_ff == ST_ROOT);

   for (genvar k = 0; k < rpg_pkg::NUM_IN_CHAN; k++) begin : g_lane
      if (k < CHANNELS) begin : g_on
         rpg_pkg::lane_win_type win;
         assign win.left_top  = win_ff[0][k*CW +: CW];
         assign win.left_mid  = win_ff[1][k*CW +: CW];
         assign win.left_bot  = win_ff[2][k*CW +: CW];
         assign win.cen_top   = win_ff[3][k*CW +: CW];
         assign win.cen_bot   = win_ff[5][k*CW +: CW];
         assign win.right_top = top_rd[k*CW +: CW];
         assign win.right_mid = mid_rd[k*CW +: CW];
         assign win.right_bot = pix_ff[k*CW +: CW];

         rpg_lane u_lane (
            .clock (clock),
            .ctrl  (lane_ctrl),
            .win   (win),
            .mag   (lane_mag[k])
         );
      end else begin : g_off
         assign lane_mag[k] = '0;
      end
   end

   // ---------------------------------------------------------------- sequencer
   // output register frees when taken; the finished result moves in once it is free
   assign out_load = (state_ff == ST_HOLD) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      out_valid_in = (out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (col_wrap) begin
               col_in = '0;
               row_in = row_wrap ? '0 : row_next[rpg_pkg::ROW_W-1:0];
            end else begin
               col_in = col_next[COL_W-1:0];
               row_in = item_row_ff;
            end
            state_in = emit ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cnt_in = cnt_ff + rpg_pkg::ROOT_CNT_W'(1);
            if (cnt_ff == rpg_pkg::ROOT_CNT_W'(rpg_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         col_ff          <= '0;
         row_ff          <= '0;
         cnt_ff          <= '0;
         out_valid_ff    <= 1'b0;
         frame_width_ff  <= rpg_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= rpg_pkg::FRAME_HEIGHT_RST;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         if (cfg_write) begin
            case (paddr[2])
               rpg_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[rpg_pkg::CFG_W-1:0];
               rpg_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[rpg_pkg::CFG_W-1:0];
               default: ;
            endcase
         end
         // window shifts one column left once the gradients are taken
         if (state_ff == ST_CALC) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top_rd;
            win_ff[4] <= mid_rd;
            win_ff[5] <= pix_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_col_ff <= start_col;
         item_row_ff <= start_row;
         pix_ff      <= {req_data.blue_in, req_data.green_in, req_data.red_in};
      end
      if (state_ff == ST_CALC) begin
         res_col_ff  <= col_m1[rpg_pkg::OUT_COL_W-1:0];
         res_row_ff  <= item_row_ff - rpg_pkg::ROW_W'(1);
         res_done_ff <= last_pix;
      end
      if (out_load) begin
         out_ff.out_column <= res_col_ff;
         out_ff.out_row    <= res_row_ff;
         out_ff.red_edge   <= lane_mag[0];
         out_ff.green_edge <= lane_mag[1];
         out_ff.blue_edge  <= lane_mag[2];
         out_ff.frame_done <= res_done_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for rgb_prewitt_gradient_magnitude_core
// depends on rpg_pkg and the core; drives pixels, csr writes and checks edge results
`timescale 1ns / 1ps

module testbench;
   import rpg_pkg::*;

   localparam int MAX_W           = MAX_WIDTH_DEF;
   localparam int SETTLE_CYCLES   = 20;     // a pixel with no result may still be in the core
   localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no transaction on either channel
   localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

   // every input has a known value from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [APB_ADDR_W-1:0] paddr     = '0;
   logic [APB_DATA_W-1:0] pwdata    = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   // pixel source and expected edge results
   req_type     pix_queue[$];
   rsp_type     edge_expect[$];
   int          pix_pushed      = 0;
   int          pix_accepted    = 0;
   int          results_seen    = 0;
   int          frame_ends      = 0;
   int          phase_count     = 0;
   int          error_count     = 0;
   int          gap_left        = 0;
   int          stall_left      = 0;
   int          quiet_cycles    = 0;
   bit          sender_idles    = 1'b1;
   bit          receiver_idles  = 1'b1;

   // predictor state: geometry, two line buffers, 3x2 window, raster position
   logic [CFG_W-1:0] cfg_width  = FRAME_WIDTH_RST;
   logic [CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;
   logic [PIX_W-1:0] upper_row  [MAX_W];
   logic [PIX_W-1:0] middle_row [MAX_W];
   // [0..2] column c-2 top/mid/bottom, [3..5] column c-1 top/mid/bottom
   logic [PIX_W-1:0] win_col    [6];
   int unsigned      col_pos    = 0;
   int unsigned      row_pos    = 0;

   rgb_prewitt_gradient_magnitude_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      error_count++;
   endtask

   // one color channel of a packed {blue, green, red} pixel
   function automatic int chan_level(input logic [PIX_W-1:0] p, input int k);
      return int'(p[CHAN_W*k +: CHAN_W]);
   endfunction

   // floor of the square root, saturated to 255
   function automatic logic [CHAN_W-1:0] root_sat(input int unsigned v);
      logic [CHAN_W-1:0] root;
      int unsigned       trial;
      root = '0;
      if (v >= 32'd65536) return 8'hff;
      for (int b = CHAN_W - 1; b >= 0; b--) begin
         trial = int'(root) | (32'd1 << b);
         if (trial * trial <= v) root[b] = 1'b1;
      end
      return root;
   endfunction

   // advance the raster model by one pixel and queue the result it causes
   task automatic predict_edges(input req_type px);
      int unsigned      w, h, c, r;
      int               dx, dy;
      logic [PIX_W-1:0] pix, top, mid;
      logic [CHAN_W-1:0] mag [3];
      rsp_type          res;
      w = (cfg_width < MIN_DIM) ? 3 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
      h = (cfg_height < MIN_DIM) ? 3 : cfg_height;
      if (px.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      pix = {px.blue_in, px.green_in, px.red_in};
      top = upper_row[c];
      mid = middle_row[c];
      // interior centre (c-1, r-1) is complete once this pixel arrives
      if (c >= 2 && r >= 2) begin
         for (int k = 0; k < NUM_IN_CHAN; k++) begin
            dx = chan_level(top, k) + chan_level(mid, k) + chan_level(pix, k)
               - chan_level(win_col[0], k) - chan_level(win_col[1], k)
               - chan_level(win_col[2], k);
            dy = chan_level(win_col[0], k) + chan_level(win_col[3], k) + chan_level(top, k)
               - chan_level(win_col[2], k) - chan_level(win_col[5], k)
               - chan_level(pix, k);
            mag[k] = root_sat(dx * dx + dy * dy);
         end
         res.out_column = OUT_COL_W'(c - 1);
         res.out_row    = ROW_W'(r - 1);
         res.red_edge   = mag[0];
         res.green_edge = mag[1];
         res.blue_edge  = mag[2];
         res.frame_done = (c == w - 1 && r == h - 1);
         edge_expect.push_back(res);
      end
      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = top;
      win_col[4] = mid;
      win_col[5] = pix;
      upper_row[c]  = mid;
      middle_row[c] = pix;
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   // pixel driver: one transaction per free slot, random gap before each pixel when sender_idles is set
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_edges(req_data);
            pix_accepted++;
            gap_left = sender_idles ? $urandom_range(0, 9) : 0;
         end
         // a stalled pixel holds its payload; otherwise the slot is free
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pix_queue.size() != 0) begin
               req_data  <= pix_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare each accepted result with the oldest expectation, then hold
   // stall, if receiver_idles is set, for a random number of cycles in which a result waits
   always @(posedge clock) begin : edge_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (edge_expect.size() == 0) begin
               report_mismatch("result with nothing pending, column",
                               32'(rsp_data.out_column), 0);
            end else begin
               want = edge_expect.pop_front();
               if (rsp_data.out_column !== want.out_column)
                  report_mismatch("out_column", 32'(rsp_data.out_column),
                                  32'(want.out_column));
               if (rsp_data.out_row !== want.out_row)
                  report_mismatch("out_row", 32'(rsp_data.out_row), 32'(want.out_row));
               if (rsp_data.red_edge !== want.red_edge)
                  report_mismatch("red_edge", 32'(rsp_data.red_edge), 32'(want.red_edge));
               if (rsp_data.green_edge !== want.green_edge)
                  report_mismatch("green_edge", 32'(rsp_data.green_edge),
                                  32'(want.green_edge));
               if (rsp_data.blue_edge !== want.blue_edge)
                  report_mismatch("blue_edge", 32'(rsp_data.blue_edge),
                                  32'(want.blue_edge));
               if (rsp_data.frame_done !== want.frame_done)
                  report_mismatch("frame_done", 32'(rsp_data.frame_done),
                                  32'(want.frame_done));
               if (want.frame_done) frame_ends++;
            end
            stall_left = receiver_idles ? $urandom_range(0, 9) : 0;
         end else if (rsp_valid && rsp_stall && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("FAIL rgb_prewitt_gradient_magnitude_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // setup cycle, access cycle; the register takes the data at the access edge
   task automatic csr_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      // upper bits are junk that the register must drop
      pwdata  <= {20'($urandom()), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == WIDTH_ADDR) cfg_width = value;
      else cfg_height = value;
   endtask

   task automatic csr_check(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[CFG_W-1:0] !== want)
         report_mismatch("csr readback", 32'(prdata[CFG_W-1:0]), 32'(want));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic push_pixel(input logic fs, input logic [CHAN_W-1:0] red,
                             input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
      req_type px;
      px.frame_start = fs;
      px.red_in      = red;
      px.green_in    = green;
      px.blue_in     = blue;
      pix_queue.push_back(px);
      pix_pushed++;
   endtask

   // wait until every pixel is taken and every result has come back
   task automatic drain_pipeline();
      while (pix_accepted != pix_pushed) @(posedge clock);
      while (edge_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // flat extremes are common so that saturation and zero gradients show up
   function automatic logic [CHAN_W-1:0] rand_level();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // new geometry while idle, then a stream that opens with frame_start;
   // noisy streams restart the frame now and then at a random pixel
   task automatic run_phase(input logic [CFG_W-1:0] width_raw, input logic [CFG_W-1:0] height_raw,
                            input int count, input bit noisy, input bit idles);
      csr_write(WIDTH_ADDR, width_raw);
      csr_write(HEIGHT_ADDR, height_raw);
      csr_check(WIDTH_ADDR, width_raw);
      csr_check(HEIGHT_ADDR, height_raw);
      sender_idles   = idles;
      receiver_idles = idles;
      for (int i = 0; i < count; i++)
         push_pixel(i == 0 || (noisy && $urandom_range(0, 99) == 0),
                    rand_level(), rand_level(), rand_level());
      drain_pipeline();
      phase_count++;
   endtask

   initial begin
      foreach (win_col[i]) win_col[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // geometry registers come out of reset at 640 x 480
      csr_check(WIDTH_ADDR, FRAME_WIDTH_RST);
      csr_check(HEIGHT_ADDR, FRAME_HEIGHT_RST);

      // directed part on the smallest frame, one interior pixel per frame
      csr_write(WIDTH_ADDR, 12'd3);
      csr_write(HEIGHT_ADDR, 12'd3);
      // saturating red, mild green ramp, checkerboard blue
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            push_pixel(r == 0 && c == 0, (c == 2 || r == 0) ? 8'hff : 8'h00,
                       CHAN_W'(c * 10 + r * 3), ((c + r) % 2 != 0) ? 8'hff : 8'h00);
      // next frame by counter wrap alone: negative gradients, flat green
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            push_pixel(1'b0, (c == 2 || r == 0) ? 8'h00 : 8'hff, 8'hff,
                       (c == 0) ? 8'hff : 8'h00);
      // partial frame cut short by a frame_start at the start of its second row
      push_pixel(1'b0, 8'hff, 8'h00, 8'hff);
      push_pixel(1'b0, 8'h00, 8'hff, 8'h00);
      push_pixel(1'b0, 8'h80, 8'h7f, 8'h01);
      push_pixel(1'b1, 8'h00, 8'h00, 8'h00);
      push_pixel(1'b0, 8'hff, 8'hff, 8'hff);
      push_pixel(1'b0, 8'h55, 8'haa, 8'hfe);
      push_pixel(1'b0, 8'haa, 8'h55, 8'h01);
      drain_pipeline();
      phase_count++;

      // random part; each phase boundary also holds the sender until all results are back
      run_phase(12'd0,    12'd0,    40,   1'b1, 1'b1);   // both below minimum
      run_phase(12'd2,    12'd1,    20,   1'b0, 1'b1);
      run_phase(12'd4,    12'd5,    80,   1'b1, 1'b1);
      run_phase(12'd17,   12'd9,    120,  1'b1, 1'b0);   // back-to-back, no receiver stalls
      run_phase(12'd4095, 12'd3,    40,   1'b0, 1'b1);   // clamped to full width
      run_phase(12'd3,    12'd4095, 100,  1'b1, 1'b1);   // tallest frame
      run_phase(12'd9,    12'd3,    90,   1'b0, 1'b1);   // several wraps
      run_phase(12'd5,    12'd3,    60,   1'b1, 1'b1);
      run_phase(12'd6,    12'd7,    60,   1'b1, 1'b0);

      if (edge_expect.size() != 0)
         report_mismatch("results never delivered", 0, edge_expect.size());
      $display("covered %0d pixels in %0d phases, %0d edge results with %0d frame ends",
               pix_accepted, phase_count, results_seen, frame_ends);
      $display("geometry from 3x3 through clamped 2048 wide and 4095 tall, %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("PASS rgb_prewitt_gradient_magnitude_core");
      end else begin
         $display("FAIL rgb_prewitt_gradient_magnitude_core");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rpg_pkg.sv
hw/rtl/rpg_ram.sv
hw/rtl/rpg_lane.sv
hw/rtl/rgb_prewitt_gradient_magnitude_core.sv
tb/testbench.sv
